[sv/bfpe_pkg.sv]
// Package for the byte ring FIFO with framed packet extraction.
// Holds widths, codes, state encodings and pointer helpers; depends on nothing.
package bfpe_pkg;

   localparam int DEPTH       = 1024;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int MAX_PAYLOAD = 55;
   localparam int FRAME_HDR   = 9;
   localparam int HDR_BYTES   = FRAME_HDR - 1;
   localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int LEVEL_W     = 10;
   localparam int LEN_W       = 2 * BYTE_W;
   localparam int PAY_CNT_W   = $clog2(MAX_PAYLOAD + 1);
   localparam int CNT_W       = (PAY_CNT_W > 4) ? PAY_CNT_W : 4;
   localparam int CMP_W       = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;

   localparam logic [BYTE_W-1:0] START_MARK = 8'h5A;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef byte_type hdr_array_type [HDR_BYTES];

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE  = 2'd0,
      MODE_READ   = 2'd1,
      MODE_PACKET = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_SHORT_BUF = 3'd3,
      STAT_NO_MARK   = 3'd4,
      STAT_SHORT_HDR = 3'd5,
      STAT_SHORT_PAY = 3'd6,
      STAT_TOO_LONG  = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_OUT,
      ST_SCAN_REQ,
      ST_SCAN_CHK,
      ST_HDR_REQ,
      ST_HDR_CAP,
      ST_CHECK,
      ST_EMIT_HDR,
      ST_PAY_REQ,
      ST_PAY_OUT
   } state_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      byte_type wdata;
      logic     re;
      addr_type raddr;
   } ram_req_type;

   // Next pointer position, wrapping at the end of the store.
   function automatic addr_type ptr_inc(addr_type p);
      return (p == addr_type'(DEPTH - 1)) ? '0 : addr_type'(p + 1'b1);
   endfunction

   // Number of bytes held between the read and write pointers.
   function automatic addr_type held_of(addr_type w, addr_type r);
      logic [ADDR_W:0] wrapped;
      wrapped = {1'b0, w} + (ADDR_W + 1)'(DEPTH) - {1'b0, r};
      if (w >= r) begin
         return addr_type'(w - r);
      end
      return wrapped[ADDR_W-1:0];
   endfunction

   // Fill level as reported on the result channel, masked to its width.
   function automatic level_type to_level(addr_type h);
      logic [LEVEL_W+ADDR_W-1:0] wide;
      wide = {{LEVEL_W{1'b0}}, h};
      return wide[LEVEL_W-1:0];
   endfunction

endpackage

[sv/bfpe_chan_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on bfpe_pkg for the field widths.
interface bfpe_req_if;
   import bfpe_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] data;
   modport source (output valid, mode, data, input ready);
   modport sink   (input valid, mode, data, output ready);
endinterface

interface bfpe_rsp_if;
   import bfpe_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_out;
   logic [STATUS_W-1:0] status;
   logic                last;
   logic [LEVEL_W-1:0]  level;
   modport source (output valid, data_out, status, last, level, input ready);
   modport sink   (input valid, data_out, status, last, level, output ready);
endinterface

[sv/bfpe_ram.sv]
// Byte store of the ring FIFO: one write port, one read port, registered read data.
// Depends on bfpe_pkg for the depth and the request struct.
module bfpe_ram (
   input  logic                  clock,
   input  bfpe_pkg::ram_req_type ram_req,
   output bfpe_pkg::byte_type    ram_rdata
);
   import bfpe_pkg::*;

   byte_type store_ff [DEPTH];
   byte_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         store_ff[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // Read data holds until the next read so a stalled consumer can wait on it.
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rdata_ff <= store_ff[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

[sv/bfpe_ctrl.sv]
// Sequencer for the ring FIFO: pointers, packet parse, header buffer and output register.
// Depends on bfpe_pkg and the channel interfaces; drives the byte store in bfpe_ram.
module bfpe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   bfpe_req_if.sink              req,
   bfpe_rsp_if.source            rsp,
   output bfpe_pkg::ram_req_type ram_req,
   input  bfpe_pkg::byte_type    ram_rdata
);
   import bfpe_pkg::*;

   state_type     state_ff, state_in;
   addr_type      rptr_ff, rptr_in;
   addr_type      wptr_ff, wptr_in;
   cnt_type       cnt_ff, cnt_in;
   hdr_array_type hdr_ff, hdr_in;
   level_type     flevel_ff, flevel_in;

   logic          rsp_valid_ff, rsp_valid_in;
   byte_type      data_out_ff, data_out_in;
   status_type    status_ff, status_in;
   logic          last_ff, last_in;
   level_type     level_ff, level_in;

   logic          slot_free;
   addr_type      held_now;
   logic [LEN_W-1:0] pkt_len;
   cnt_type       len_s;
   cnt_type       cnt_m1;
   logic          emit;
   byte_type      e_data;
   status_type    e_status;
   logic          e_last;
   logic          use_flevel;
   level_type     e_level;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign held_now  = held_of(wptr_ff, rptr_ff);
   // Header bytes five and six, counting the mark as byte zero.
   assign pkt_len   = {hdr_ff[4], hdr_ff[5]};
   assign len_s     = pkt_len[CNT_W-1:0];
   assign cnt_m1    = cnt_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      flevel_ff   <= flevel_in;
      data_out_ff <= data_out_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      level_ff    <= level_in;
   end

   always_comb begin
      state_in      = state_ff;
      rptr_in       = rptr_ff;
      wptr_in       = wptr_ff;
      cnt_in        = cnt_ff;
      hdr_in        = hdr_ff;
      flevel_in     = flevel_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = wptr_ff;
      ram_req.wdata = req.data;
      ram_req.re    = 1'b0;
      ram_req.raddr = rptr_ff;
      req.ready     = 1'b0;
      emit          = 1'b0;
      e_data        = '0;
      e_status      = STAT_OK;
      e_last        = 1'b1;
      use_flevel    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = slot_free;
            if (req.valid && slot_free) begin
               unique case (mode_type'(req.mode))
                  MODE_WRITE: begin
                     emit = 1'b1;
                     if (held_now == addr_type'(DEPTH - 1)) begin
                        e_status = STAT_FULL;
                     end else begin
                        ram_req.we = 1'b1;
                        wptr_in    = ptr_inc(wptr_ff);
                     end
                  end
                  MODE_READ: begin
                     if (held_now == '0) begin
                        emit     = 1'b1;
                        e_status = STAT_EMPTY;
                     end else begin
                        ram_req.re = 1'b1;
                        rptr_in    = ptr_inc(rptr_ff);
                        state_in   = ST_RD_OUT;
                     end
                  end
                  MODE_PACKET: begin
                     if (held_now < addr_type'(FRAME_HDR)) begin
                        emit     = 1'b1;
                        e_status = STAT_SHORT_BUF;
                     end else begin
                        cnt_in   = '0;
                        state_in = ST_SCAN_REQ;
                     end
                  end
                  MODE_CLEAR: begin
                     emit    = 1'b1;
                     rptr_in = '0;
                     wptr_in = '0;
                  end
               endcase
            end
         end
         ST_RD_OUT: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_data   = ram_rdata;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_REQ: begin
            ram_req.re = 1'b1;
            rptr_in    = ptr_inc(rptr_ff);
            state_in   = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (ram_rdata == START_MARK) begin
               if (held_now < addr_type'(FRAME_HDR)) begin
                  if (slot_free) begin
                     emit     = 1'b1;
                     e_status = STAT_SHORT_HDR;
                     state_in = ST_IDLE;
                  end
               end else begin
                  cnt_in   = '0;
                  state_in = ST_HDR_REQ;
               end
            end else if (cnt_ff == cnt_type'(FRAME_HDR - 1)) begin
               if (slot_free) begin
                  emit     = 1'b1;
                  e_status = STAT_NO_MARK;
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_SCAN_REQ;
            end
         end
         ST_HDR_REQ: begin
            ram_req.re = 1'b1;
            rptr_in    = ptr_inc(rptr_ff);
            state_in   = ST_HDR_CAP;
         end
         ST_HDR_CAP: begin
            hdr_in[cnt_ff[HDR_IDX_W-1:0]] = ram_rdata;
            if (cnt_ff == cnt_type'(HDR_BYTES - 1)) begin
               state_in = ST_CHECK;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_HDR_REQ;
            end
         end
         ST_CHECK: begin
            if (pkt_len > LEN_W'(MAX_PAYLOAD)) begin
               if (slot_free) begin
                  emit     = 1'b1;
                  e_status = STAT_TOO_LONG;
                  state_in = ST_IDLE;
               end
            end else if (CMP_W'(held_now) < CMP_W'(len_s)) begin
               if (slot_free) begin
                  emit     = 1'b1;
                  e_status = STAT_SHORT_PAY;
                  state_in = ST_IDLE;
               end
            end else begin
               // Every result of the packet reports the level after the payload is gone.
               flevel_in = to_level(addr_type'(CMP_W'(held_now) - CMP_W'(len_s)));
               cnt_in    = '0;
               state_in  = ST_EMIT_HDR;
            end
         end
         ST_EMIT_HDR: begin
            if (slot_free) begin
               emit       = 1'b1;
               use_flevel = 1'b1;
               e_data     = (cnt_ff == '0) ? START_MARK : hdr_ff[cnt_m1[HDR_IDX_W-1:0]];
               e_last     = (cnt_ff == cnt_type'(HDR_BYTES)) && (len_s == '0);
               if (cnt_ff == cnt_type'(HDR_BYTES)) begin
                  cnt_in   = '0;
                  state_in = (len_s == '0) ? ST_IDLE : ST_PAY_REQ;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_PAY_REQ: begin
            ram_req.re = 1'b1;
            rptr_in    = ptr_inc(rptr_ff);
            state_in   = ST_PAY_OUT;
         end
         ST_PAY_OUT: begin
            if (slot_free) begin
               emit       = 1'b1;
               use_flevel = 1'b1;
               e_data     = ram_rdata;
               e_last     = (cnt_type'(cnt_ff + 1'b1) == len_s);
               cnt_in     = cnt_ff + 1'b1;
               state_in   = e_last ? ST_IDLE : ST_PAY_REQ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      e_level = use_flevel ? flevel_ff : to_level(held_of(wptr_in, rptr_in));

      rsp_valid_in = rsp_valid_ff;
      data_out_in  = data_out_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      level_in     = level_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         data_out_in  = e_data;
         status_in    = e_status;
         last_in      = e_last;
         level_in     = e_level;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.data_out = data_out_ff;
   assign rsp.status   = status_ff;
   assign rsp.last     = last_ff;
   assign rsp.level    = level_ff;

endmodule

[sv/byte_ring_fifo_packet_extract.sv]
// Top level of the byte ring FIFO with length-framed packet extraction.
// Depends on bfpe_pkg, bfpe_chan_if, bfpe_ram and bfpe_ctrl.
//
//   Channel   Direction  Payload                          Transfer when
//   req_ch    in         mode[1:0], data[7:0]             valid && ready
//   rsp_ch    out        data_out[7:0], status[2:0],      valid && ready
//                        last, level[9:0]
//
// Byte writes, failed reads and clears are taken from the idle state and their single
// result sits in the output register in the next cycle. A byte read passes
// through ST_RD_OUT, since the store returns data in the cycle after the read address.
// In a packet read, each byte fetched from the store is a request state followed
// by a use state on the single read port. Reset clears the pointers and the
// control state only; the store needs no clearing pass because only held bytes
// are ever read. A stalled response holds the block in place without loss.
module byte_ring_fifo_packet_extract (
   input  logic       clock,
   input  logic       reset,
   bfpe_req_if.sink   req_ch,
   bfpe_rsp_if.source rsp_ch
);
   import bfpe_pkg::*;

   ram_req_type ram_req;
   byte_type    ram_rdata;

   // The sequencer runs one request at a time, so a write to the store always
   // lands before any later read of the same entry is issued.
   bfpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   bfpe_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

`ifndef NO_ASSERTIONS
   // The store is written only by a byte write transfer on the request side.
   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (req_ch.valid && req_ch.ready))
      else $error("byte store written without a request transfer");

   // Reads and writes of the store never share a cycle.
   a_no_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.we && ram_req.re))
      else $error("byte store read and written in the same cycle");

   // Any failure result is the only result of its request and carries no byte.
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STAT_OK)) |-> (rsp_ch.last && (rsp_ch.data_out == '0)))
      else $error("failure result not final or carries data");

   // A new request is never taken while a result waits and is not being taken.
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while the output register is stalled");
`endif

endmodule
